### hw/rtl/tte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants of the text terminal character engine.
// ----------------------------------------------------------------------------
package tte_pkg;

  // result command codes
  typedef enum logic [2:0] {
    CMD_WRITE      = 3'd0,
    CMD_RECOLOR    = 3'd1,
    CMD_SCROLL     = 3'd2,
    CMD_CLR_ROW    = 3'd3,
    CMD_CLR_SCREEN = 3'd4,
    CMD_CURSOR     = 3'd5
  } cmd_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS    = 2'd0,
    REG_ROWS       = 2'd1,
    REG_BACK_COLOR = 2'd2
  } reg_idx_t;

  localparam int MAX_COLUMNS_DEF  = 128;
  localparam int MAX_ROWS_DEF     = 64;
  localparam int ESCAPE_DEPTH_DEF = 16;

  localparam logic [7:0] COLUMNS_RST    = 8'd80;
  localparam logic [6:0] ROWS_RST       = 7'd25;
  localparam logic [3:0] BACK_COLOR_RST = 4'd0;
  localparam logic [3:0] FORE_RST       = 4'd15;

  // commands caused by one byte, at most
  localparam int MAX_RESULTS = 6;
  localparam int LST_IDX_W   = $clog2(MAX_RESULTS);
  localparam int LST_LEN_W   = $clog2(MAX_RESULTS + 1);

  // character codes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LC_M  = 8'h6D;
  localparam logic [7:0] CH_UC_J  = 8'h4A;
  localparam logic [7:0] CH_UC_K  = 8'h4B;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // escape arguments
  localparam logic [31:0] SGR_FG_LO     = 32'd30;
  localparam logic [31:0] SGR_FG_HI     = 32'd37;
  localparam logic [31:0] SGR_BRIGHT_LO = 32'd90;
  localparam logic [31:0] SGR_BRIGHT_HI = 32'd97;
  localparam logic [31:0] SGR_BRIGHT_OF = 32'd82;
  localparam logic [31:0] ERASE_ALL     = 32'd2;

  // output tdata layout
  localparam int OUT_TDATA_W = 40;

endpackage : tte_pkg
`default_nettype wire

### hw/rtl/text_terminal_char_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_terminal_char_engine
// Usage:
//   in_*  : one character byte per request (tdata[7:0]).
//   out_* : drawing commands; tuser carries the command code, tlast marks the
//           final command caused by a byte. tdata carries cell index, glyph,
//           foreground, background and row to clear.
//   cfg_* : register writes (0 columns, 1 rows, 2 background color), always
//           ready; write only while the engine is idle.
// Timing:
//   a byte is taken into the input register, decoded into the command list,
//   and each command leaves via the output register, one per cycle while
//   out_tready is high. Escape bytes produce no command but for a final J or K
//   with argument 2, and are consumed at one byte per cycle while no command
//   is pending. Commands per byte: up to 6 for a backspace, 4 for a printable
//   byte, 3 for a line feed, 2 for others. The next byte is taken as they drain.
// Reset: synchronous, active low; cursor to cell 0, foreground 15, no escape
//   active, registers to 80 columns, 25 rows, background 0.
// Stall: a stalled out request holds its command; the list and input register
//   fill, then in_tready drops.
// ----------------------------------------------------------------------------
module text_terminal_char_engine
  import tte_pkg::*;
#(
  parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS     = MAX_ROWS_DEF,
  parameter int ESCAPE_DEPTH = ESCAPE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input bytes
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] char_byte
  // commands
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [12:0] cell_index, [20:13] glyph,
                                                  // [24:21] fore_color,
                                                  // [28:25] back_color_out,
                                                  // [34:29] clear_row, [39:35] zero
  output logic [2:0]                  out_tuser,  // [2:0] command
  output logic                        out_tlast,  // last
  // configuration
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]             cfg_data
);

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int ECW   = $clog2(MAX_COLUMNS + 1);
  localparam int ERW   = $clog2(MAX_ROWS + 1);
  localparam int ESC_W = $clog2(ESCAPE_DEPTH + 1);
  localparam int CIW   = RW + ECW;

  // configuration
  logic [7:0] cfg_columns_r;
  logic [6:0] cfg_rows_r;
  logic [3:0] cfg_back_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_columns_r <= COLUMNS_RST;
      cfg_rows_r    <= ROWS_RST;
      cfg_back_r    <= BACK_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLUMNS:    cfg_columns_r <= cfg_data;
        REG_ROWS:       cfg_rows_r    <= cfg_data[6:0];
        REG_BACK_COLOR: cfg_back_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [ECW-1:0] eff_cols;
  logic [ERW-1:0] eff_rows;

  always_comb begin
    if (cfg_columns_r == 8'd0) eff_cols = ECW'(1);
    else if (32'(cfg_columns_r) > MAX_COLUMNS) eff_cols = ECW'(MAX_COLUMNS);
    else eff_cols = ECW'(cfg_columns_r);
    if (cfg_rows_r == 7'd0) eff_rows = ERW'(1);
    else if (32'(cfg_rows_r) > MAX_ROWS) eff_rows = ERW'(MAX_ROWS);
    else eff_rows = ERW'(cfg_rows_r);
  end

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // terminal state
  logic [CW-1:0]    cur_col_r, cur_col_nxt;
  logic [RW-1:0]    cur_row_r, cur_row_nxt;
  logic [3:0]       fore_r, fore_nxt;
  logic [ESC_W-1:0] esc_cnt_r, esc_cnt_nxt;
  logic [31:0]      esc_num_r, esc_num_nxt;

  // command list
  cmd_t           lst_cmd_r   [MAX_RESULTS];
  logic [CW-1:0]  lst_col_r   [MAX_RESULTS];
  logic [RW-1:0]  lst_row_r   [MAX_RESULTS];
  logic [7:0]     lst_glyph_r [MAX_RESULTS];
  logic [LST_LEN_W-1:0] lst_len_r;
  logic [LST_IDX_W-1:0] lst_rd_r;

  cmd_t           e_cmd   [MAX_RESULTS];
  logic [CW-1:0]  e_col   [MAX_RESULTS];
  logic [RW-1:0]  e_row   [MAX_RESULTS];
  logic [7:0]     e_glyph [MAX_RESULTS];
  logic [LST_LEN_W-1:0] e_len;

  // output register
  logic out_valid_r;
  logic out_load, pop, proc;

  assign out_load  = !out_valid_r || out_tready;
  assign pop       = out_load && (lst_len_r != '0);
  assign proc      = in_valid_r &&
                     ((lst_len_r == '0) || ((lst_len_r == LST_LEN_W'(1)) && pop));
  assign in_tready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  function automatic logic [CW+RW-1:0] step_back(input logic [CW-1:0] col,
                                                 input logic [RW-1:0] row,
                                                 input logic [ECW-1:0] ncols);
    logic [CW-1:0] c;
    logic [RW-1:0] r;
    c = col;
    r = row;
    if (col == '0) begin
      c = CW'(ncols - ECW'(1));
      if (row != '0) r = row - RW'(1);
    end else begin
      c = col - CW'(1);
    end
    return {r, c};
  endfunction

  // decode one byte into state update and command list
  always_comb begin
    logic [7:0]           c;
    logic [CW-1:0]        col_v;
    logic [RW-1:0]        row_v;
    logic [7:0]           glyph_v;
    logic [LST_IDX_W-1:0] n;
    logic [31:0]          digit;

    c           = in_byte_r;
    n           = '0;
    fore_nxt    = fore_r;
    esc_cnt_nxt = esc_cnt_r;
    esc_num_nxt = esc_num_r;
    digit       = {{24{c[7]}}, c} - {24'd0, CH_ZERO};
    for (int i = 0; i < MAX_RESULTS; i++) begin
      e_cmd[i]   = CMD_WRITE;
      e_col[i]   = '0;
      e_row[i]   = '0;
      e_glyph[i] = '0;
    end

    // clamp into the current screen size
    col_v = (ECW'(cur_col_r) >= eff_cols) ? CW'(eff_cols - ECW'(1)) : cur_col_r;
    row_v = (ERW'(cur_row_r) >= eff_rows) ? RW'(eff_rows - ERW'(1)) : cur_row_r;
    glyph_v = (c == CH_BS) ? CH_SPACE : c;

    if ((c == CH_ESC) || (esc_cnt_r != '0)) begin
      if (esc_cnt_r < ESC_W'(ESCAPE_DEPTH)) esc_cnt_nxt = esc_cnt_r + ESC_W'(1);
      if (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) begin
        if (c == CH_LC_M) begin
          if (esc_num_r inside {[SGR_FG_LO:SGR_FG_HI]}) begin
            fore_nxt = 4'(esc_num_r - SGR_FG_LO);
          end else if (esc_num_r inside {[SGR_BRIGHT_LO:SGR_BRIGHT_HI]}) begin
            fore_nxt = 4'(esc_num_r - SGR_BRIGHT_OF);
          end
        end else if (c == CH_UC_J) begin
          if (esc_num_r == ERASE_ALL) begin
            e_cmd[n] = CMD_CLR_SCREEN;
            n        = n + LST_IDX_W'(1);
            col_v    = '0;
            row_v    = '0;
            e_cmd[n] = CMD_CURSOR;
            n        = n + LST_IDX_W'(1);
          end
        end else if (c == CH_UC_K) begin
          if (esc_num_r == ERASE_ALL) begin
            e_cmd[n] = CMD_CLR_ROW;
            e_row[n] = row_v;
            n        = n + LST_IDX_W'(1);
          end
        end
        esc_cnt_nxt = '0;
        esc_num_nxt = '0;
      end else if (esc_cnt_r >= ESC_W'(2)) begin
        esc_num_nxt = (esc_num_r << 3) + (esc_num_r << 1) + digit;
      end
    end else begin
      if (((c >= CH_SPACE) && (c < CH_DEL)) || (c == CH_BS)) begin
        if (c == CH_BS) {row_v, col_v} = step_back(col_v, row_v, eff_cols);
        // write the cell and advance
        e_cmd[n]   = CMD_WRITE;
        e_col[n]   = col_v;
        e_row[n]   = row_v;
        e_glyph[n] = glyph_v;
        n          = n + LST_IDX_W'(1);
        if (ECW'(col_v) + ECW'(1) >= eff_cols) begin
          col_v = '0;
          if (ERW'(row_v) + ERW'(1) >= eff_rows) begin
            e_cmd[n] = CMD_SCROLL;
            n        = n + LST_IDX_W'(1);
          end else begin
            row_v = row_v + RW'(1);
          end
        end else begin
          col_v = col_v + CW'(1);
        end
        e_cmd[n] = CMD_RECOLOR;
        e_col[n] = col_v;
        e_row[n] = row_v;
        n        = n + LST_IDX_W'(1);
        e_cmd[n] = CMD_CURSOR;
        e_col[n] = col_v;
        e_row[n] = row_v;
        n        = n + LST_IDX_W'(1);
        if (c == CH_BS) {row_v, col_v} = step_back(col_v, row_v, eff_cols);
      end else if (c == CH_LF) begin
        col_v = '0;
        if (ERW'(row_v) + ERW'(1) >= eff_rows) begin
          e_cmd[n] = CMD_SCROLL;
          n        = n + LST_IDX_W'(1);
        end else begin
          row_v = row_v + RW'(1);
        end
      end else if (c == CH_CR) begin
        col_v = '0;
      end
      if (!((c >= CH_SPACE) && (c < CH_DEL))) begin
        e_cmd[n] = CMD_RECOLOR;
        e_col[n] = col_v;
        e_row[n] = row_v;
        n        = n + LST_IDX_W'(1);
        e_cmd[n] = CMD_CURSOR;
        e_col[n] = col_v;
        e_row[n] = row_v;
        n        = n + LST_IDX_W'(1);
      end
    end

    cur_col_nxt = col_v;
    cur_row_nxt = row_v;
    e_len       = LST_LEN_W'(n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      fore_r    <= FORE_RST;
      esc_cnt_r <= '0;
      esc_num_r <= '0;
      lst_len_r <= '0;
      lst_rd_r  <= '0;
    end else if (proc) begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      fore_r    <= fore_nxt;
      esc_cnt_r <= esc_cnt_nxt;
      esc_num_r <= esc_num_nxt;
      lst_len_r <= e_len;
      lst_rd_r  <= '0;
    end else if (pop) begin
      lst_len_r <= lst_len_r - LST_LEN_W'(1);
      lst_rd_r  <= lst_rd_r + LST_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        lst_cmd_r[i]   <= e_cmd[i];
        lst_col_r[i]   <= e_col[i];
        lst_row_r[i]   <= e_row[i];
        lst_glyph_r[i] <= e_glyph[i];
      end
    end
  end

  // result fields of the list head
  cmd_t         hd_cmd;
  logic [CIW-1:0] hd_cell_full;
  logic [12:0]  hd_cell;
  logic [7:0]   hd_glyph;
  logic [3:0]   hd_fore;
  logic [3:0]   hd_back;
  logic [5:0]   hd_crow;

  assign hd_cmd       = lst_cmd_r[lst_rd_r];
  assign hd_cell_full = CIW'(lst_col_r[lst_rd_r]) +
                        CIW'(lst_row_r[lst_rd_r]) * CIW'(eff_cols);

  always_comb begin
    hd_cell  = '0;
    hd_glyph = '0;
    hd_fore  = '0;
    hd_back  = cfg_back_r;
    hd_crow  = '0;
    case (hd_cmd)
      CMD_WRITE: begin
        hd_cell  = 13'(hd_cell_full);
        hd_glyph = lst_glyph_r[lst_rd_r];
        hd_fore  = fore_r;
      end
      CMD_RECOLOR: begin
        hd_cell = 13'(hd_cell_full);
        hd_fore = fore_r;
      end
      CMD_CLR_ROW: hd_crow = 6'(lst_row_r[lst_rd_r]);
      CMD_CURSOR: begin
        hd_cell = 13'(hd_cell_full);
        hd_back = '0;
      end
      default: ;
    endcase
  end

  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [2:0]             out_cmd_r;
  logic                   out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= (lst_len_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= {5'd0, hd_crow, hd_back, hd_fore, hd_glyph, hd_cell};
      out_cmd_r  <= hd_cmd;
      out_last_r <= (lst_len_r == LST_LEN_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cmd_r;
  assign out_tlast  = out_last_r;

endmodule : text_terminal_char_engine
`default_nettype wire

### hw/rtl/tte_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tte_checker
// Port-level checks of the command stream of the terminal engine.
// ----------------------------------------------------------------------------
module tte_checker
  import tte_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [2:0]             out_tuser,
  input wire logic                   out_tlast
);

  // stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("out request changed while stalled");

  // fill commands carry no cell
  a_fill_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == CMD_SCROLL || out_tuser == CMD_CLR_ROW ||
                   out_tuser == CMD_CLR_SCREEN) |-> out_tdata[20:0] == '0)
    else $error("fill command with cell or glyph");

  // clear screen is never the last command of its byte
  a_clr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CMD_CLR_SCREEN |-> !out_tlast)
    else $error("clear screen marked last");

  // cursor move carries only a cell
  a_cursor_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CMD_CURSOR |-> out_tdata[OUT_TDATA_W-1:13] == '0)
    else $error("cursor command with color or glyph");

endmodule : tte_checker

bind text_terminal_char_engine tte_checker u_tte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
